@@ hw/rtl/bsm_pkg.sv @@
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants for the 3x3 RGB box smoothing filter.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int MAX_SIDE   = 1024;
  localparam int SIDE_MIN   = 2;
  localparam int SIDE_RESET = 32;
  localparam int SIDE_W     = 11;
  localparam int COL_W      = $clog2(MAX_SIDE);

  localparam int CH_W  = 16;
  localparam int NCH   = 3;
  localparam int PIX_W = NCH * CH_W;
  localparam int NWIN  = 3;

  // 9 * (2^CH_W - 1) fits
  localparam int SUM_W    = CH_W + 4;
  localparam int RECIP_W  = 23;
  localparam int RECIP_SH = 24;
  localparam int PROD_W   = SUM_W + RECIP_W;

  // ceil(2^24 / d); exact floor for sums below 2^20
  localparam logic [RECIP_W-1:0] RECIP_DIV4 = RECIP_W'(4194304);
  localparam logic [RECIP_W-1:0] RECIP_DIV6 = RECIP_W'(2796203);
  localparam logic [RECIP_W-1:0] RECIP_DIV9 = RECIP_W'(1864136);

  localparam int MAX_RES = 4;
  localparam int CNT_W   = 3;
  localparam int IDX_W   = 2;

  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int CRED_W = $clog2(QDEPTH + 1);

  // [2] red, [1] green, [0] blue
  typedef logic [NCH-1:0][CH_W-1:0] pix_t;
  typedef logic [NCH-1:0][SUM_W-1:0] sum_t;

  typedef struct packed {
    logic i_ge1;
    logic i_ge2;
    logic i_last;
    logic j_ge1;
    logic j_ge2;
    logic j_last;
  } pos_t;

  typedef struct packed {
    logic [CNT_W-1:0]       cnt;
    logic                   corner;
    pix_t [MAX_RES-1:0]     slot;
  } grp_t;

  function automatic logic [RECIP_W-1:0] recip_sel(input logic three_rows,
                                                   input logic three_cols);
    logic [RECIP_W-1:0] r;
    if (three_rows && three_cols) begin
      r = RECIP_DIV9;
    end else if (three_rows || three_cols) begin
      r = RECIP_DIV6;
    end else begin
      r = RECIP_DIV4;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/box_smooth_3x3_rgb.sv @@
// ----------------------------------------------------------------------------
// box_smooth_3x3_rgb
// Streaming 3x3 mean filter over a square RGB image in raster order.
// A completing pixel passes registers s1, s2 and s3, the group queue and the
// output register before out_valid rises. Throughput: one pixel per cycle while
// queue credit lasts; a row-end pixel gives 2 results, a bottom-row pixel 2, the
// corner 4, one per cycle unless out_ready stalls; bottom rows run at half rate.
// Reset: side 32, counters zero; line stores are not cleared, no sweep.
// ----------------------------------------------------------------------------
module box_smooth_3x3_rgb import bsm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIDE_W-1:0] cfg_image_side,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CH_W-1:0]   in_red,
  input  logic [CH_W-1:0]   in_green,
  input  logic [CH_W-1:0]   in_blue,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CH_W-1:0]   out_red,
  output logic [CH_W-1:0]   out_green,
  output logic [CH_W-1:0]   out_blue,
  output logic              out_run_last,
  output logic              out_frame_last
);

  logic grp_push, grp_pop, head_vld;
  grp_t grp_data, head;

  bsm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_image_side (cfg_image_side),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .grp_pop        (grp_pop),
    .grp_push       (grp_push),
    .grp_data       (grp_data)
  );

  bsm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (grp_push),
    .push_data (grp_data),
    .pop       (grp_pop),
    .head_vld  (head_vld),
    .head      (head)
  );

  bsm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_vld       (head_vld),
    .head           (head),
    .pop            (grp_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_run_last   (out_run_last),
    .out_frame_last (out_frame_last)
  );

endmodule

@@ hw/rtl/bsm_ram.sv @@
// ----------------------------------------------------------------------------
// bsm_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/bsm_front.sv @@
// ----------------------------------------------------------------------------
// bsm_front
// Pixel intake: position counters, line stores, 3x3 window, sums and
// reciprocal divide. Pushes one result group per pixel into the queue.
// ----------------------------------------------------------------------------
module bsm_front import bsm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIDE_W-1:0] cfg_image_side,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CH_W-1:0]   in_red,
  input  logic [CH_W-1:0]   in_green,
  input  logic [CH_W-1:0]   in_blue,
  input  logic              grp_pop,
  output logic              grp_push,
  output grp_t              grp_data
);

  logic [SIDE_W-1:0] side_r, side_nxt, side_wr;
  logic [COL_W-1:0]  row_r, row_nxt, col_r, col_nxt, side_m1;
  logic [CRED_W-1:0] credit_r, credit_nxt;
  logic              cfg_wr, acc;
  pos_t              pos;

  logic              s1_vld_r, s2_vld_r, s3_vld_r;
  pos_t              s1_pos_r, s2_pos_r;
  pix_t              s1_px_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [2*PIX_W-1:0] ram_rdata;

  pix_t win_r [NWIN][NWIN];

  sum_t full [NWIN];
  sum_t bot  [NWIN];
  sum_t vs   [NWIN];
  sum_t res_sum [MAX_RES];
  logic [RECIP_W-1:0] res_recip [MAX_RES];
  logic [MAX_RES-1:0] res_emit;
  logic row_lo, col_lo;

  sum_t               s3_sum_r   [MAX_RES];
  logic [RECIP_W-1:0] s3_recip_r [MAX_RES];
  logic [MAX_RES-1:0] s3_emit_r;
  logic [PROD_W-1:0]  prod [MAX_RES][NCH];
  pix_t               quo  [MAX_RES];

  // configuration
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    side_wr = cfg_image_side;
    if (cfg_image_side < SIDE_W'(SIDE_MIN)) begin
      side_wr = SIDE_W'(SIDE_MIN);
    end else if (cfg_image_side > SIDE_W'(MAX_SIDE)) begin
      side_wr = SIDE_W'(MAX_SIDE);
    end
  end

  assign side_nxt = cfg_wr ? side_wr : side_r;
  assign side_m1  = COL_W'(side_r - SIDE_W'(1));

  // intake and position
  assign in_ready = credit_r < CRED_W'(QDEPTH);
  assign acc      = in_valid && in_ready;

  assign pos.i_ge1  = row_r != '0;
  assign pos.i_ge2  = row_r >= COL_W'(2);
  assign pos.i_last = row_r == side_m1;
  assign pos.j_ge1  = col_r != '0;
  assign pos.j_ge2  = col_r >= COL_W'(2);
  assign pos.j_last = col_r == side_m1;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_wr) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (acc) begin
      if (pos.j_last) begin
        col_nxt = '0;
        row_nxt = pos.i_last ? '0 : row_r + COL_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  assign credit_nxt = credit_r + CRED_W'(acc) - CRED_W'(grp_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r   <= SIDE_W'(SIDE_RESET);
      row_r    <= '0;
      col_r    <= '0;
      credit_r <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      side_r   <= side_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      credit_r <= credit_nxt;
      s1_vld_r <= acc;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // line stores: {older row, newer row}; rewritten in the cycle after the read
  bsm_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_SIDE)
  ) u_line (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_col_r),
    .wdata ({ram_rdata[PIX_W-1:0], s1_px_r}),
    .re    (acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_px_r  <= {in_red, in_green, in_blue};
      s1_pos_r <= pos;
      s1_col_r <= col_r;
    end
    if (s1_vld_r) begin
      for (int r = 0; r < NWIN; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= ram_rdata[2*PIX_W-1:PIX_W];
      win_r[1][2] <= ram_rdata[PIX_W-1:0];
      win_r[2][2] <= s1_px_r;
      s2_pos_r    <= s1_pos_r;
    end
  end

  // window sums
  assign row_lo = !s2_pos_r.i_ge2;
  assign col_lo = !s2_pos_r.j_ge2;

  always_comb begin
    for (int c = 0; c < NWIN; c++) begin
      for (int ch = 0; ch < NCH; ch++) begin
        bot[c][ch]  = SUM_W'(win_r[1][c][ch]) + SUM_W'(win_r[2][c][ch]);
        full[c][ch] = bot[c][ch] + SUM_W'(win_r[0][c][ch]);
        vs[c][ch]   = row_lo ? bot[c][ch] : full[c][ch];
      end
    end
    for (int ch = 0; ch < NCH; ch++) begin
      res_sum[0][ch] = (col_lo ? '0 : vs[0][ch]) + vs[1][ch] + vs[2][ch];
      res_sum[1][ch] = vs[1][ch] + vs[2][ch];
      res_sum[2][ch] = (col_lo ? '0 : bot[0][ch]) + bot[1][ch] + bot[2][ch];
      res_sum[3][ch] = bot[1][ch] + bot[2][ch];
    end
    res_recip[0] = recip_sel(!row_lo, !col_lo);
    res_recip[1] = recip_sel(!row_lo, 1'b0);
    res_recip[2] = recip_sel(1'b0, !col_lo);
    res_recip[3] = recip_sel(1'b0, 1'b0);
    // A: (i-1,j-1)  B: (i-1,j)  C: (i,j-1)  D: (i,j)
    res_emit[0] = s2_pos_r.i_ge1  && s2_pos_r.j_ge1;
    res_emit[1] = s2_pos_r.i_ge1  && s2_pos_r.j_last;
    res_emit[2] = s2_pos_r.i_last && s2_pos_r.j_ge1;
    res_emit[3] = s2_pos_r.i_last && s2_pos_r.j_last;
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      for (int k = 0; k < MAX_RES; k++) begin
        s3_sum_r[k]   <= res_sum[k];
        s3_recip_r[k] <= res_recip[k];
      end
      s3_emit_r <= res_emit;
    end
  end

  // divide by reciprocal multiply, then compact into a group
  always_comb begin
    for (int k = 0; k < MAX_RES; k++) begin
      for (int ch = 0; ch < NCH; ch++) begin
        prod[k][ch] = PROD_W'(s3_sum_r[k][ch]) * PROD_W'(s3_recip_r[k]);
        quo[k][ch]  = prod[k][ch][RECIP_SH +: CH_W];
      end
    end
  end

  // B implies A, C implies A, D implies all
  assign grp_push        = s3_vld_r;
  assign grp_data.cnt    = CNT_W'(s3_emit_r[0]) + CNT_W'(s3_emit_r[1])
                         + CNT_W'(s3_emit_r[2]) + CNT_W'(s3_emit_r[3]);
  assign grp_data.corner = s3_emit_r[3];
  assign grp_data.slot[0] = quo[0];
  assign grp_data.slot[1] = s3_emit_r[1] ? quo[1] : quo[2];
  assign grp_data.slot[2] = quo[2];
  assign grp_data.slot[3] = quo[3];

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CRED_W'(QDEPTH))
    else $error("item credit above queue depth");

endmodule

@@ hw/rtl/bsm_queue.sv @@
// ----------------------------------------------------------------------------
// bsm_queue
// Short FIFO of result groups between intake and output sides.
// ----------------------------------------------------------------------------
module bsm_queue import bsm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t push_data,
  input  logic pop,
  output logic head_vld,
  output grp_t head
);

  grp_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign head_vld = cnt_r != '0;
  assign head     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != (QPTR_W+1)'(QDEPTH)))
    else $error("group queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_vld)
    else $error("group queue underflow");

endmodule

@@ hw/rtl/bsm_back.sv @@
// ----------------------------------------------------------------------------
// bsm_back
// Output side: walks each queued group and presents one result item per
// cycle, while out_ready allows, through an output register.
// ----------------------------------------------------------------------------
module bsm_back import bsm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_vld,
  input  grp_t            head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CH_W-1:0] out_red,
  output logic [CH_W-1:0] out_green,
  output logic [CH_W-1:0] out_blue,
  output logic            out_run_last,
  output logic            out_frame_last
);

  logic             out_valid_r;
  pix_t             out_pix_r;
  logic             run_last_r, frame_last_r;
  logic [IDX_W-1:0] idx_r;
  logic             load, last, take;

  assign load = !out_valid_r || out_ready;
  assign last = (CNT_W'(idx_r) + CNT_W'(1)) == head.cnt;
  assign take = head_vld && load && (head.cnt != '0);
  assign pop  = head_vld && load && ((head.cnt == '0) || last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        idx_r       <= last ? '0 : idx_r + IDX_W'(1);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_pix_r    <= head.slot[idx_r];
      run_last_r   <= last;
      frame_last_r <= last && head.corner;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_pix_r[2];
  assign out_green      = out_pix_r[1];
  assign out_blue       = out_pix_r[0];
  assign out_run_last   = run_last_r;
  assign out_frame_last = frame_last_r;

  a_frame_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && frame_last_r) |-> run_last_r)
    else $error("frame end not at end of run");

  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    (head_vld && (head.cnt != '0)) |-> (CNT_W'(idx_r) < head.cnt))
    else $error("slot index beyond group");

endmodule
